// ===== rtl/core/ttsc_pkg.sv =====
package ttsc_pkg;

  localparam int TABLE_DEPTH = 10;

  localparam int SCORE_W = 16;
  localparam int DUR_W   = 32;
  localparam int CNT_W   = 16;
  localparam int RANK_W  = 4;
  localparam int SUM_W   = 16;

  localparam logic [31:0] SIGNATURE = 32'h034E_424F;

  // Seed is the low signature half plus twice the high half, modulo 2^16.
  localparam logic [SUM_W-1:0] SEED =
    SUM_W'({16'h0000, SIGNATURE[15:0]} + {15'h0000, SIGNATURE[31:16], 1'b0});

  typedef logic [SCORE_W-1:0] score_t;
  typedef logic [SUM_W-1:0]   term_t;

endpackage

// ===== rtl/core/ttsc_if.sv =====
interface ttsc_run_if;
  logic                          valid;
  logic                          ready;
  logic [ttsc_pkg::SCORE_W-1:0] new_score;
  logic [ttsc_pkg::DUR_W-1:0]   run_duration;

  modport source (output valid, output new_score, output run_duration, input ready);
  modport sink   (input valid, input new_score, input run_duration, output ready);
endinterface

interface ttsc_report_if;
  logic                         valid;
  logic                         ready;
  logic [ttsc_pkg::RANK_W-1:0]  placed_rank;
  logic [ttsc_pkg::SUM_W-1:0]   record_checksum;
  logic [ttsc_pkg::CNT_W-1:0]   runs_total;
  logic [ttsc_pkg::DUR_W-1:0]   duration_total;

  modport source (output valid, output placed_rank, output record_checksum,
                  output runs_total, output duration_total, input ready);
  modport sink   (input valid, input placed_rank, input record_checksum,
                  input runs_total, input duration_total, output ready);
endinterface

// ===== rtl/core/ttsc_cell.sv =====
module ttsc_cell #(
  parameter int WEIGHT = 3
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  ttsc_pkg::score_t score_in,
  input  ttsc_pkg::score_t upper_entry,
  input  logic             upper_lt,
  output ttsc_pkg::score_t entry,
  output logic             lt,
  output logic             ins,
  output ttsc_pkg::term_t  term
);

  localparam ttsc_pkg::term_t W = ttsc_pkg::SUM_W'(WEIGHT);

  ttsc_pkg::score_t entry_next;

  assign lt  = entry < score_in;
  // The insertion point is the top cell whose entry is below the new score.
  assign ins = lt & ~upper_lt;

  always_comb begin
    entry_next = entry;
    if (load && lt) begin
      entry_next = upper_lt ? upper_entry : score_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry <= '0;
    end else begin
      entry <= entry_next;
    end
  end

  always_ff @(posedge clk) begin
    term <= ttsc_pkg::SUM_W'(entry * W);
  end

endmodule

// ===== rtl/core/ttsc_sum.sv =====
module ttsc_sum #(
  parameter int N_TERMS = ttsc_pkg::TABLE_DEPTH + 3
) (
  input  logic            clk,
  input  ttsc_pkg::term_t terms [N_TERMS],
  output ttsc_pkg::term_t sum
);

  localparam int N_GROUPS = (N_TERMS + 3) / 4;

  ttsc_pkg::term_t grp [N_GROUPS];

  // First level: groups of four terms, registered.
  for (genvar g = 0; g < N_GROUPS; g++) begin : g_grp
    ttsc_pkg::term_t part [5];
    assign part[0] = '0;
    for (genvar k = 0; k < 4; k++) begin : g_k
      if (g * 4 + k < N_TERMS) begin : g_use
        assign part[k+1] = part[k] + terms[g*4+k];
      end else begin : g_pad
        assign part[k+1] = part[k];
      end
    end
    always_ff @(posedge clk) begin
      grp[g] <= part[4];
    end
  end

  // Second level: seed plus all group sums.
  ttsc_pkg::term_t acc [N_GROUPS+1];
  assign acc[0] = ttsc_pkg::SEED;
  for (genvar g = 0; g < N_GROUPS; g++) begin : g_acc
    assign acc[g+1] = acc[g] + grp[g];
  end
  assign sum = acc[N_GROUPS];

endmodule

// ===== rtl/core/top_ten_score_table_with_checksum_unit.sv =====
// Channel  Dir  Fields                                          Handshake
// run      in   new_score[15:0], run_duration[31:0]            valid/ready
// report   out  placed_rank[3:0], record_checksum[15:0],       valid/ready
//               runs_total[15:0], duration_total[31:0]
//
// On acceptance the table shifts; the weighted terms and group sums are then
// registered in turn, and the final sum goes into the report register.
// The block takes no new request while one is on the checksum path; a new
// request is taken in the cycle after the previous one reaches the report
// register. Reset clears the table, count, duration and the report valid.
// A stalled report holds its register and stops the next request at the
// final sum until it is taken.
module top_ten_score_table_with_checksum_unit #(
  parameter int TABLE_DEPTH = ttsc_pkg::TABLE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  ttsc_run_if.sink             run,
  ttsc_report_if.source        report
);

  localparam int N_TERMS = TABLE_DEPTH + 3;
  localparam int RANK_IW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TERM = 2'd1;
  localparam logic [1:0] S_GRP  = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  logic accept;
  logic fin_load;

  ttsc_pkg::score_t entry [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] lt;
  logic [TABLE_DEPTH-1:0] ins;
  ttsc_pkg::term_t terms [N_TERMS];
  ttsc_pkg::term_t count_term;
  ttsc_pkg::term_t dur_lo_term;
  ttsc_pkg::term_t dur_hi_term;

  logic [ttsc_pkg::CNT_W-1:0] run_counter;
  logic [ttsc_pkg::DUR_W-1:0] duration_sum;
  logic [ttsc_pkg::RANK_W-1:0] rank_hold;
  logic [RANK_IW-1:0] rank_or;
  logic [RANK_IW-1:0] rank_calc;
  ttsc_pkg::term_t checksum;

  assign accept    = run.valid && run.ready;
  assign run.ready = (state == S_IDLE);
  assign fin_load  = (state == S_FIN) && (!report.valid || report.ready);

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ttsc_pkg::score_t up_entry;
    logic             up_lt;
    if (i == 0) begin : g_head
      assign up_entry = '0;
      assign up_lt    = 1'b0;
    end else begin : g_link
      assign up_entry = entry[i-1];
      assign up_lt    = lt[i-1];
    end
    ttsc_cell #(.WEIGHT(i + 3)) u_cell (
      .clk         (clk),
      .rst         (rst),
      .load        (accept),
      .score_in    (run.new_score),
      .upper_entry (up_entry),
      .upper_lt    (up_lt),
      .entry       (entry[i]),
      .lt          (lt[i]),
      .ins         (ins[i]),
      .term        (terms[i])
    );
  end

  // Rank is the index of the one insertion cell, or the depth if none.
  always_comb begin
    rank_or = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (ins[i]) begin
        rank_or = rank_or | RANK_IW'(i);
      end
    end
    rank_calc = (|ins) ? rank_or : RANK_IW'(TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_counter  <= '0;
      duration_sum <= '0;
    end else if (accept) begin
      run_counter  <= run_counter + 1'b1;
      duration_sum <= duration_sum + run.run_duration;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rank_hold <= ttsc_pkg::RANK_W'(rank_calc);
    end
  end

  always_ff @(posedge clk) begin
    count_term  <= ttsc_pkg::SUM_W'(run_counter * ttsc_pkg::SUM_W'(TABLE_DEPTH + 3));
    dur_lo_term <= ttsc_pkg::SUM_W'(duration_sum[15:0] *
                                    ttsc_pkg::SUM_W'(TABLE_DEPTH + 4));
    dur_hi_term <= ttsc_pkg::SUM_W'(duration_sum[31:16] *
                                    ttsc_pkg::SUM_W'(TABLE_DEPTH + 5));
  end

  assign terms[TABLE_DEPTH]   = count_term;
  assign terms[TABLE_DEPTH+1] = dur_lo_term;
  assign terms[TABLE_DEPTH+2] = dur_hi_term;

  ttsc_sum #(.N_TERMS(N_TERMS)) u_sum (
    .clk   (clk),
    .terms (terms),
    .sum   (checksum)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_TERM;
        end
      end
      S_TERM: state_next = S_GRP;
      S_GRP:  state_next = S_FIN;
      S_FIN: begin
        if (fin_load) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      report.valid <= 1'b0;
    end else if (fin_load) begin
      report.valid <= 1'b1;
    end else if (report.ready) begin
      report.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      report.placed_rank     <= rank_hold;
      report.record_checksum <= checksum;
      report.runs_total      <= run_counter;
      report.duration_total  <= duration_sum;
    end
  end

  a_ins_unique: assert property (@(posedge clk) disable iff (rst)
    $onehot0(ins))
    else $error("more than one insertion point in the score table");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == S_TERM))
    else $error("accepted request did not start the checksum path");

  a_report_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(report.valid) |-> ($past(state) == S_FIN))
    else $error("report raised outside the final sum step");

  for (genvar i = 1; i < TABLE_DEPTH; i++) begin : g_chk
    a_sorted: assert property (@(posedge clk) disable iff (rst)
      entry[i-1] >= entry[i])
      else $error("score table out of order");
  end

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TOTAL_RUNS  = 1400;
  // The last stretch of requests runs with no idling on either side.
  localparam int CALM_RUNS   = 200;
  localparam int HOLD_CYCLES = 80;

  typedef struct packed {
    ttsc_pkg::score_t           score;
    logic [ttsc_pkg::DUR_W-1:0] frames;
  } run_req_t;

  typedef struct packed {
    logic [ttsc_pkg::RANK_W-1:0] rank;
    logic [ttsc_pkg::SUM_W-1:0]  checksum;
    logic [ttsc_pkg::CNT_W-1:0]  runs;
    logic [ttsc_pkg::DUR_W-1:0]  frames;
  } run_report_t;

  logic clk;
  logic rst;

  ttsc_run_if    run_bus ();
  ttsc_report_if report_bus ();

  top_ten_score_table_with_checksum_unit i_dut (
    .clk    (clk),
    .rst    (rst),
    .run    (run_bus),
    .report (report_bus)
  );

  // Predicted state of the score record.
  ttsc_pkg::score_t leader_board [ttsc_pkg::TABLE_DEPTH] = '{default: '0};
  logic [ttsc_pkg::CNT_W-1:0] runs_seen   = '0;
  logic [ttsc_pkg::DUR_W-1:0] frames_seen = '0;

  run_req_t    pending_runs [$];
  run_report_t reports_due  [$];

  int runs_planned;
  int idle_limit;
  int runs_driven   = 0;
  int runs_accepted = 0;
  int reports_taken = 0;
  int mismatches    = 0;
  int placed_runs   = 0;
  int unplaced_runs = 0;
  int tied_runs     = 0;
  int send_gap      = 0;
  int hold_left     = 0;
  int longest_hold  = 0;
  bit pressure_done = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic flag_mismatch(string what, longint unsigned got, longint unsigned want);
    mismatches++;
    $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  // Inserts one finished run into the predicted record and forms its report.
  function automatic run_report_t post_run(ttsc_pkg::score_t score,
                                           logic [ttsc_pkg::DUR_W-1:0] frames);
    run_report_t                r;
    int                         rank;
    int                         i;
    logic [ttsc_pkg::SUM_W-1:0] acc;
    rank = ttsc_pkg::TABLE_DEPTH;
    while (rank > 0 && leader_board[rank-1] < score) begin
      rank--;
      if (rank + 1 < ttsc_pkg::TABLE_DEPTH) leader_board[rank+1] = leader_board[rank];
    end
    if (rank < ttsc_pkg::TABLE_DEPTH) begin
      leader_board[rank] = score;
      placed_runs++;
      if (rank > 0 && leader_board[rank-1] == score) tied_runs++;
    end else begin
      unplaced_runs++;
    end
    runs_seen   = runs_seen + 1'b1;
    frames_seen = frames_seen + frames;

    acc = ttsc_pkg::SIGNATURE[15:0];
    acc = acc + ttsc_pkg::SIGNATURE[31:16] + ttsc_pkg::SIGNATURE[31:16];
    for (i = 0; i < ttsc_pkg::TABLE_DEPTH; i++)
      acc = acc + 16'(leader_board[i] * (i + 3));
    acc = acc + 16'(runs_seen * (ttsc_pkg::TABLE_DEPTH + 3));
    acc = acc + 16'(frames_seen[15:0] * (ttsc_pkg::TABLE_DEPTH + 4));
    acc = acc + 16'(frames_seen[31:16] * (ttsc_pkg::TABLE_DEPTH + 5));

    r.rank     = ttsc_pkg::RANK_W'(rank);
    r.checksum = acc;
    r.runs     = runs_seen;
    r.frames   = frames_seen;
    return r;
  endfunction

  function automatic ttsc_pkg::score_t pick_score();
    ttsc_pkg::score_t pool [8] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                                   16'hFFFE, 16'hFFFF, 16'hFF80, 16'h0100};
    case ($urandom_range(0, 9))
      0, 1, 2: return ttsc_pkg::score_t'($urandom);
      3, 4:    return pool[$urandom_range(0, 7)];
      5, 6:    return ttsc_pkg::score_t'($urandom_range(0, 255));
      default: return ttsc_pkg::score_t'($urandom_range(16'hFF00, 16'hFFFF));
    endcase
  endfunction

  function automatic logic [ttsc_pkg::DUR_W-1:0] pick_frames();
    case ($urandom_range(0, 9))
      6:       return '0;
      7:       return '1;
      8, 9:    return ttsc_pkg::DUR_W'($urandom_range(0, 1000));
      default: return ttsc_pkg::DUR_W'($urandom);
    endcase
  endfunction

  task automatic queue_run(ttsc_pkg::score_t score, logic [ttsc_pkg::DUR_W-1:0] frames);
    run_req_t req;
    req.score  = score;
    req.frames = frames;
    pending_runs.push_back(req);
  endtask

  // Idling stays off in every fourth stretch of 150 requests and for the
  // last 200 requests.
  function automatic bit idling_allowed();
    return runs_accepted < idle_limit && (runs_accepted / 150) % 4 != 3;
  endfunction

  // Sender: a request stays on the bus until it is taken.
  always @(negedge clk) begin
    run_req_t nxt;
    if (rst) begin
      run_bus.valid        <= 1'b0;
      run_bus.new_score    <= '0;
      run_bus.run_duration <= '0;
    end else if (run_bus.valid && runs_accepted != runs_driven) begin
      // still waiting for the current request to be taken
    end else if (send_gap > 0) begin
      run_bus.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_runs.size() == 0) begin
      run_bus.valid <= 1'b0;
    end else if (idling_allowed() && $urandom_range(0, 7) == 0) begin
      run_bus.valid <= 1'b0;
      send_gap <= $urandom_range(0, 11);
    end else begin
      nxt = pending_runs.pop_front();
      run_bus.valid        <= 1'b1;
      run_bus.new_score    <= nxt.score;
      run_bus.run_duration <= nxt.frames;
      runs_driven          <= runs_driven + 1;
    end
  end

  // Receiver: random stalls plus one long hold-off to back up the block.
  always @(negedge clk) begin
    if (rst) begin
      report_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      report_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && runs_accepted >= 320) begin
      report_bus.ready <= 1'b0;
      pressure_done    <= 1'b1;
      hold_left        <= HOLD_CYCLES - 1;
      longest_hold     <= HOLD_CYCLES;
    end else if (idling_allowed() && $urandom_range(0, 6) == 0) begin
      report_bus.ready <= 1'b0;
      hold_left <= $urandom_range(0, 11);
    end else begin
      report_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    run_report_t want;
    if (!rst) begin
      if (report_bus.valid && report_bus.ready) begin
        reports_taken++;
        if (reports_due.size() == 0) begin
          flag_mismatch("report with no request pending", report_bus.runs_total, 0);
        end else begin
          want = reports_due.pop_front();
          if (report_bus.placed_rank !== want.rank)
            flag_mismatch("placed_rank", report_bus.placed_rank, want.rank);
          if (report_bus.record_checksum !== want.checksum)
            flag_mismatch("record_checksum", report_bus.record_checksum, want.checksum);
          if (report_bus.runs_total !== want.runs)
            flag_mismatch("runs_total", report_bus.runs_total, want.runs);
          if (report_bus.duration_total !== want.frames)
            flag_mismatch("duration_total", report_bus.duration_total, want.frames);
        end
      end
      if (run_bus.valid && run_bus.ready) begin
        reports_due.push_back(post_run(run_bus.new_score, run_bus.run_duration));
        runs_accepted <= runs_accepted + 1;
      end
    end
  end

  initial begin
    rst = 1'b1;

    // Directed: ties, a score equal to the last entry, field extremes and a
    // duration wrap, while the table fills and then shifts.
    queue_run(16'h0000, 32'h0000_0000);
    queue_run(16'hFFFF, 32'hFFFF_FFFF);
    queue_run(16'hFFFF, 32'h0000_0001);
    queue_run(16'h0001, 32'h0000_0000);
    queue_run(16'h8000, 32'h8000_0000);
    queue_run(16'h8000, 32'h7FFF_FFFF);
    queue_run(16'h7FFF, 32'h5555_5555);
    queue_run(16'h5555, 32'hAAAA_AAAA);
    queue_run(16'hAAAA, 32'h0001_0000);
    queue_run(16'h0002, 32'h0000_FFFF);
    queue_run(16'h0003, 32'h0000_0003);
    queue_run(16'h0001, 32'h0000_000A);
    queue_run(16'h0000, 32'h0000_0000);
    queue_run(16'h0002, 32'h0000_0005);
    queue_run(16'hFFFF, 32'h0000_0007);
    queue_run(16'hFFFE, 32'h1234_5678);
    queue_run(16'h0004, 32'hFFFF_FFFF);
    queue_run(16'h7FFF, 32'hFFFF_0000);
    queue_run(16'h8001, 32'h0000_0064);

    idle_limit = TOTAL_RUNS - CALM_RUNS;
    while (pending_runs.size() < TOTAL_RUNS) queue_run(pick_score(), pick_frames());
    runs_planned = pending_runs.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (runs_accepted < runs_planned || reports_due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Checked %0d reports for %0d requests: %0d placed (%0d tied), %0d not placed.",
             reports_taken, runs_accepted, placed_runs, tied_runs, unplaced_runs);
    $display("Longest receiver hold-off was %0d cycles; final run count 0x%0h.",
             longest_hold, runs_seen);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout with %0d of %0d requests taken.", runs_accepted, runs_planned);
    $display("FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/ttsc_pkg.sv
rtl/core/ttsc_if.sv
rtl/core/ttsc_cell.sv
rtl/core/ttsc_sum.sv
rtl/core/top_ten_score_table_with_checksum_unit.sv
tb/tb.sv
